// ===== rtl/core/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Operation and status codes, and the arctangent table and angle constants
// used by the vectoring stages of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAG = 3'd4,
    OP_ANG = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  // angle datapath: Q30 radians, operands scaled by 2^28
  localparam int CORDIC_STEPS = 31;
  localparam int ANG_FRAC     = 30;
  localparam int ANG_PRESCALE = 28;
  localparam int ZW           = 35;

  localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;

  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001
  };

endpackage

// ===== rtl/core/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU: add, subtract, multiply, divide, magnitude and angle
// on signed fixed-point operands, with saturation and divide-by-zero status.
// ----------------------------------------------------------------------------
// One operation is taken on every cycle in which start is high; busy is tied
// low, so every start beat is accepted. Each beat gives exactly one result,
// shown for one cycle with done_o high, after the capture, product, sum, split
// and setup stages, the iteration stages (NSTEP is the larger of the 31
// vectoring steps of the angle path and the DATA_WIDTH + 2 quotient bits of
// the divider) and the output register. Results leave in the order the
// operations came in. The latency is the same for every operation code, and
// the receiver cannot stall the block, so done_o must be sampled on every cycle.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   operation_i,
  input  logic signed [DATA_WIDTH-1:0] a_re_i,
  input  logic signed [DATA_WIDTH-1:0] a_im_i,
  input  logic signed [DATA_WIDTH-1:0] b_re_i,
  input  logic signed [DATA_WIDTH-1:0] b_im_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] res_re_o,
  output logic signed [DATA_WIDTH-1:0] res_im_o,
  output logic [1:0]                   status_o
);

  // datapath widths
  localparam int DW    = DATA_WIDTH;
  localparam int MW    = 2 * DW;                 // products, |b|^2, |a|^2
  localparam int SW    = MW + 1;                 // sum of two products
  localparam int QB    = DW + 2;                 // quotient bits (one extra for rounding)
  localparam int NW    = MW + FRAC_BITS + 1;     // scaled dividend
  localparam int CW    = DW + 31;                // vectoring x / y
  localparam int NSTEP = (CORDIC_STEPS > QB) ? CORDIC_STEPS : QB;
  localparam int FITW  = (MW + 2 > ZW) ? MW + 2 : ZW;
  localparam int ZSH   = ANG_FRAC - FRAC_BITS;

  // clamp a sign / magnitude pair into DW bits, bit DW flags saturation
  function automatic logic [DW:0] fit(input logic neg, input logic [FITW-1:0] mag);
    logic [FITW-1:0] lim;
    logic [DW:0]     r;
    lim = FITW'(1) << (DW - 1);
    if (neg) begin
      if (mag > lim) r = {1'b1, 1'b1, {(DW-1){1'b0}}};
      else           r = {1'b0, DW'(FITW'(0) - mag)};
    end else begin
      if (mag > lim - FITW'(1)) r = {1'b1, 1'b0, {(DW-1){1'b1}}};
      else                      r = {1'b0, mag[DW-1:0]};
    end
    return r;
  endfunction

  // state carried through the shared iteration pipeline
  typedef struct packed {
    logic [2:0]    op;
    logic          fixed;      // result already known, just ride along
    logic [DW-1:0] e_re;
    logic [DW-1:0] e_im;
    logic [1:0]    e_st;
    logic          dneg_re;
    logic          dneg_im;
    logic          dovf_re;
    logic          dovf_im;
    logic [MW-1:0] den;
    logic [MW-1:0] r_re;
    logic [MW-1:0] r_im;
    logic [QB-1:0] n_re;
    logic [QB-1:0] n_im;
    logic [QB-1:0] q_re;
    logic [QB-1:0] q_im;
    logic [MW-1:0] s;
    logic [DW+1:0] rem;
    logic [DW-1:0] root;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [ZW-1:0] z;
  } iter_t;

  // the block never holds off a start beat
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // stage 1: operand capture
  // --------------------------------------------------------------------------
  logic                 v1_q;
  logic [2:0]           op1_q;
  logic signed [DW-1:0] ar1_q, ai1_q, br1_q, bi1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start;
  end

  always_ff @(posedge clk_i) begin
    op1_q <= operation_i;
    ar1_q <= a_re_i;
    ai1_q <= a_im_i;
    br1_q <= b_re_i;
    bi1_q <= b_im_i;
  end

  // --------------------------------------------------------------------------
  // stage 2: the eight partial products, plus the add / subtract sums
  // --------------------------------------------------------------------------
  logic                 v2_q;
  logic [2:0]           op2_q;
  logic signed [DW-1:0] ar2_q, ai2_q;
  logic signed [MW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [MW-1:0] p_bbr_q, p_bbi_q, p_aar_q, p_aai_q;
  logic signed [DW:0]   as_re_d, as_im_d, as_re_q, as_im_q;

  always_comb begin
    if (op1_q == OP_SUB) begin
      as_re_d = (DW+1)'(ar1_q) - (DW+1)'(br1_q);
      as_im_d = (DW+1)'(ai1_q) - (DW+1)'(bi1_q);
    end else begin
      as_re_d = (DW+1)'(ar1_q) + (DW+1)'(br1_q);
      as_im_d = (DW+1)'(ai1_q) + (DW+1)'(bi1_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    op2_q   <= op1_q;
    ar2_q   <= ar1_q;
    ai2_q   <= ai1_q;
    p_rr_q  <= ar1_q * br1_q;
    p_ii_q  <= ai1_q * bi1_q;
    p_ri_q  <= ar1_q * bi1_q;
    p_ir_q  <= ai1_q * br1_q;
    p_bbr_q <= br1_q * br1_q;
    p_bbi_q <= bi1_q * bi1_q;
    p_aar_q <= ar1_q * ar1_q;
    p_aai_q <= ai1_q * ai1_q;
    as_re_q <= as_re_d;
    as_im_q <= as_im_d;
  end

  // --------------------------------------------------------------------------
  // stage 3: product sums, |b|^2, |a|^2, add / subtract saturation
  // --------------------------------------------------------------------------
  logic                 v3_q;
  logic [2:0]           op3_q;
  logic signed [DW-1:0] ar3_q, ai3_q;
  logic signed [SW-1:0] sum_re_d, sum_im_d, sum_re_q, sum_im_q;
  logic [MW-1:0]        den3_q, msq3_q;
  logic [DW:0]          asm_re, asm_im;
  logic [DW:0]          asf_re_q, asf_im_q;

  always_comb begin
    if (op2_q == OP_MUL) begin
      sum_re_d = SW'(p_rr_q) - SW'(p_ii_q);
      sum_im_d = SW'(p_ri_q) + SW'(p_ir_q);
    end else begin
      // divide numerator: a * conj(b)
      sum_re_d = SW'(p_rr_q) + SW'(p_ii_q);
      sum_im_d = SW'(p_ir_q) - SW'(p_ri_q);
    end
    asm_re = as_re_q[DW] ? (DW+1)'(0) - as_re_q : as_re_q;
    asm_im = as_im_q[DW] ? (DW+1)'(0) - as_im_q : as_im_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    op3_q    <= op2_q;
    ar3_q    <= ar2_q;
    ai3_q    <= ai2_q;
    sum_re_q <= sum_re_d;
    sum_im_q <= sum_im_d;
    den3_q   <= p_bbr_q + p_bbi_q;
    msq3_q   <= p_aar_q + p_aai_q;
    asf_re_q <= fit(as_re_q[DW], FITW'(asm_re));
    asf_im_q <= fit(as_im_q[DW], FITW'(asm_im));
  end

  // --------------------------------------------------------------------------
  // stage 4: sign / magnitude split of the product sums
  // --------------------------------------------------------------------------
  logic                 v4_q;
  logic [2:0]           op4_q;
  logic signed [DW-1:0] ar4_q, ai4_q;
  logic                 neg_re4_q, neg_im4_q;
  logic [MW-1:0]        mag_re4_q, mag_im4_q, den4_q, msq4_q;
  logic [DW:0]          asf_re4_q, asf_im4_q;
  logic [DW:0]          asf_re3_fwd, asf_im3_fwd;

  assign asf_re3_fwd = asf_re_q;
  assign asf_im3_fwd = asf_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    op4_q     <= op3_q;
    ar4_q     <= ar3_q;
    ai4_q     <= ai3_q;
    neg_re4_q <= sum_re_q[SW-1];
    neg_im4_q <= sum_im_q[SW-1];
    mag_re4_q <= MW'(sum_re_q[SW-1] ? SW'(0) - sum_re_q : sum_re_q);
    mag_im4_q <= MW'(sum_im_q[SW-1] ? SW'(0) - sum_im_q : sum_im_q);
    den4_q    <= den3_q;
    msq4_q    <= msq3_q;
    asf_re4_q <= asf_re3_fwd;
    asf_im4_q <= asf_im3_fwd;
  end

  // --------------------------------------------------------------------------
  // stage 5: finish multiply, set up divider, root and vectoring
  // --------------------------------------------------------------------------
  logic [NSTEP:0] iv_q;
  iter_t          it_q [NSTEP+1];
  iter_t          it_d;

  always_comb begin
    logic [FITW-1:0]      mr_re, mr_im;
    logic [DW:0]          mf_re, mf_im;
    logic [NW-1:0]        nw_re, nw_im;
    logic signed [CW-1:0] xs, ys;
    it_d = '0;
    it_d.op = op4_q;

    // multiply: round half away from zero, then clamp
    mr_re = (FITW'(mag_re4_q) + (FITW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    mr_im = (FITW'(mag_im4_q) + (FITW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    mf_re = fit(neg_re4_q, mr_re);
    mf_im = fit(neg_im4_q, mr_im);

    // divide: dividend is |num| * 2^(FRAC_BITS+1), QB quotient bits remain
    nw_re = NW'(mag_re4_q) << (FRAC_BITS + 1);
    nw_im = NW'(mag_im4_q) << (FRAC_BITS + 1);
    it_d.den     = den4_q;
    it_d.dneg_re = neg_re4_q;
    it_d.dneg_im = neg_im4_q;
    it_d.dovf_re = NW'(nw_re[NW-1:QB]) >= NW'(den4_q);
    it_d.dovf_im = NW'(nw_im[NW-1:QB]) >= NW'(den4_q);
    it_d.r_re    = MW'(nw_re[NW-1:QB]);
    it_d.r_im    = MW'(nw_im[NW-1:QB]);
    it_d.n_re    = nw_re[QB-1:0];
    it_d.n_im    = nw_im[QB-1:0];

    // root: radicand shifts out two bits a step
    it_d.s = msq4_q;

    // angle: fold the left half-plane onto the right, preload +-pi
    xs = CW'(ar4_q) <<< ANG_PRESCALE;
    ys = CW'(ai4_q) <<< ANG_PRESCALE;
    if (ar4_q[DW-1]) begin
      it_d.x = CW'(0) - xs;
      it_d.y = CW'(0) - ys;
      it_d.z = ai4_q[DW-1] ? ZW'(0) - PI_Q30 : PI_Q30;
    end else begin
      it_d.x = xs;
      it_d.y = ys;
    end

    case (op4_q)
      OP_ADD, OP_SUB: begin
        it_d.fixed = 1'b1;
        it_d.e_re  = asf_re4_q[DW-1:0];
        it_d.e_im  = asf_im4_q[DW-1:0];
        it_d.e_st  = (asf_re4_q[DW] | asf_im4_q[DW]) ? ST_SAT : ST_OK;
      end
      OP_MUL: begin
        it_d.fixed = 1'b1;
        it_d.e_re  = mf_re[DW-1:0];
        it_d.e_im  = mf_im[DW-1:0];
        it_d.e_st  = (mf_re[DW] | mf_im[DW]) ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        if (den4_q == '0) begin
          it_d.fixed = 1'b1;
          it_d.e_st  = ST_DIVZ;
        end
      end
      OP_MAG: begin
        it_d.fixed = 1'b0;
      end
      OP_ANG: begin
        // zero vector has angle zero
        it_d.fixed = (ar4_q == '0) && (ai4_q == '0);
      end
      default: begin
        it_d.fixed = 1'b1;
        it_d.e_st  = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) iv_q[0] <= 1'b0;
    else         iv_q[0] <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    it_q[0] <= it_d;
  end

  // --------------------------------------------------------------------------
  // iteration stages: one quotient bit per divider, one root bit and one
  // vectoring rotation per stage; a unit that is done just holds its state
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    localparam int AI = (k < CORDIC_STEPS) ? k : 0;
    iter_t nxt;

    always_comb begin
      logic [MW:0]          t_re, t_im;
      logic [DW+3:0]        rem4, trial;
      logic signed [CW-1:0] dx, dy;
      nxt   = it_q[k];
      t_re  = '0;
      t_im  = '0;
      rem4  = '0;
      trial = '0;
      dx    = '0;
      dy    = '0;

      if (k < QB) begin
        t_re = {it_q[k].r_re, it_q[k].n_re[QB-1]};
        t_im = {it_q[k].r_im, it_q[k].n_im[QB-1]};
        if (t_re >= {1'b0, it_q[k].den}) begin
          nxt.r_re = MW'(t_re - {1'b0, it_q[k].den});
          nxt.q_re = {it_q[k].q_re[QB-2:0], 1'b1};
        end else begin
          nxt.r_re = t_re[MW-1:0];
          nxt.q_re = {it_q[k].q_re[QB-2:0], 1'b0};
        end
        if (t_im >= {1'b0, it_q[k].den}) begin
          nxt.r_im = MW'(t_im - {1'b0, it_q[k].den});
          nxt.q_im = {it_q[k].q_im[QB-2:0], 1'b1};
        end else begin
          nxt.r_im = t_im[MW-1:0];
          nxt.q_im = {it_q[k].q_im[QB-2:0], 1'b0};
        end
        nxt.n_re = it_q[k].n_re << 1;
        nxt.n_im = it_q[k].n_im << 1;
      end

      if (k < DW) begin
        rem4  = {it_q[k].rem, it_q[k].s[MW-1 -: 2]};
        trial = {2'b00, it_q[k].root, 2'b01};
        if (rem4 >= trial) begin
          nxt.rem  = (DW+2)'(rem4 - trial);
          nxt.root = {it_q[k].root[DW-2:0], 1'b1};
        end else begin
          nxt.rem  = rem4[DW+1:0];
          nxt.root = {it_q[k].root[DW-2:0], 1'b0};
        end
        nxt.s = it_q[k].s << 2;
      end

      if (k < CORDIC_STEPS) begin
        dx = $signed(it_q[k].y) >>> k;
        dy = $signed(it_q[k].x) >>> k;
        if ($signed(it_q[k].y) > 0) begin
          nxt.x = it_q[k].x + dx;
          nxt.y = it_q[k].y - dy;
          nxt.z = it_q[k].z + ZW'(ATAN_Q30[AI]);
        end else begin
          nxt.x = it_q[k].x - dx;
          nxt.y = it_q[k].y + dy;
          nxt.z = it_q[k].z - ZW'(ATAN_Q30[AI]);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) iv_q[k+1] <= 1'b0;
      else         iv_q[k+1] <= iv_q[k];
    end

    always_ff @(posedge clk_i) begin
      it_q[k+1] <= nxt;
    end
  end

  // --------------------------------------------------------------------------
  // output stage: round and clamp quotient, root and angle, pick the result
  // --------------------------------------------------------------------------
  iter_t          fin;
  logic           done_q;
  logic [DW-1:0]  res_re_d, res_im_d, res_re_q, res_im_q;
  logic [1:0]     status_d, status_q;

  assign fin = it_q[NSTEP];

  always_comb begin
    logic [QB:0]     dq_re, dq_im;
    logic [DW:0]     df_re, df_im, sf, af;
    logic [DW:0]     rt;
    logic [ZW-1:0]   zm, zr;

    // quotient carries one extra bit: add one, drop it
    dq_re = ((QB+1)'(fin.q_re) + (QB+1)'(1)) >> 1;
    dq_im = ((QB+1)'(fin.q_im) + (QB+1)'(1)) >> 1;
    df_re = fit(fin.dneg_re, fin.dovf_re ? '1 : FITW'(dq_re));
    df_im = fit(fin.dneg_im, fin.dovf_im ? '1 : FITW'(dq_im));

    // root rounds up when the remainder passes the root
    rt = (fin.rem > (DW+2)'(fin.root)) ? (DW+1)'(fin.root) + (DW+1)'(1)
                                       : (DW+1)'(fin.root);
    sf = fit(1'b0, FITW'(rt));

    zm = fin.z[ZW-1] ? ZW'(0) - fin.z : fin.z;
    zr = (zm + (ZW'(1) << (ZSH - 1))) >> ZSH;
    af = fit(fin.z[ZW-1], FITW'(zr));

    res_re_d = fin.e_re;
    res_im_d = fin.e_im;
    status_d = fin.e_st;
    if (!fin.fixed) begin
      case (fin.op)
        OP_DIV: begin
          res_re_d = df_re[DW-1:0];
          res_im_d = df_im[DW-1:0];
          status_d = (df_re[DW] | df_im[DW]) ? ST_SAT : ST_OK;
        end
        OP_MAG: begin
          res_re_d = sf[DW-1:0];
          res_im_d = '0;
          status_d = sf[DW] ? ST_SAT : ST_OK;
        end
        OP_ANG: begin
          res_re_d = af[DW-1:0];
          res_im_d = '0;
          status_d = af[DW] ? ST_SAT : ST_OK;
        end
        default: begin
          res_re_d = fin.e_re;
          res_im_d = fin.e_im;
          status_d = fin.e_st;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= iv_q[NSTEP];
  end

  always_ff @(posedge clk_i) begin
    res_re_q <= res_re_d;
    res_im_q <= res_im_d;
    status_q <= status_d;
  end

  assign done_o   = done_q;
  assign res_re_o = res_re_q;
  assign res_im_o = res_im_q;
  assign status_o = status_q;

endmodule
